// ----- rtl/core/rsi_pkg.sv -----
// Shared constants and types for the relative strength index block.
package rsi_pkg;

  // Field and register widths
  localparam int PRICE_W  = 16;
  localparam int FRAC_W   = 16;
  localparam int PERIOD_W = 7;
  localparam int RSI_W    = 14;

  // Period register: reset value and the clamp applied on use
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 7'd14;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN = 7'd2;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = 7'd64;

  // Datapath widths. Warm-up sums cover at most 64 changes; averages carry
  // FRAC_W fraction bits on top of the sum width.
  localparam int CNT_BITS = 6;
  localparam int SUM_W    = PRICE_W + CNT_BITS;
  localparam int AVG_W    = SUM_W + FRAC_W;
  localparam int DEN_W    = AVG_W + 1;
  localparam int SCALE_W  = 14;
  localparam int PROD_W   = AVG_W + SCALE_W;
  localparam int SMTH_W   = AVG_W + PERIOD_W;
  localparam int STEP_W   = $clog2(AVG_W + 1);

  // Output scale and the no-movement value
  localparam logic [SCALE_W-1:0] RSI_FULL = 14'd10000;
  localparam logic [RSI_W-1:0]   RSI_EVEN = 14'd5000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PLOAD,
    ST_PDIV,
    ST_PSTORE,
    ST_RLOAD,
    ST_RDIV,
    ST_EMIT
  } rsi_state_e;

endpackage

// ----- rtl/core/rsi_price_if.sv -----
// Valid/ready channel carrying one closing price per word.
interface rsi_price_if;
  logic                         valid;
  logic                         ready;
  logic [rsi_pkg::PRICE_W-1:0]  close_price;

  modport source (output valid, output close_price, input ready);
  modport sink   (input valid, input close_price, output ready);
endinterface

// ----- rtl/core/rsi_result_if.sv -----
// Valid/ready channel carrying one RSI value per word.
interface rsi_result_if;
  logic                       valid;
  logic                       ready;
  logic [rsi_pkg::RSI_W-1:0]  rsi_value;

  modport source (output valid, output rsi_value, input ready);
  modport sink   (input valid, input rsi_value, output ready);
endinterface

// ----- rtl/core/relative_strength_index.sv -----
// Wilder RSI: a price is taken only in ST_IDLE. A warm-up word adds to the sums, the word
// ending the warm-up runs the average division, and a warmed word runs the average then
// the ratio division. A result still waiting in the output register holds the sequencer.
// The shared radix-2 divider gives 38 quotient bits for both averages in parallel, then 14
// for the ratio. Results wait in an output register while the next price is taken.
// Async active-low reset clears the averages, seeding and warm-up; period resets to 14.
module relative_strength_index (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rsi_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  rsi_price_if.sink                     price_i,
  rsi_result_if.source                  rsi_o
);
  import rsi_pkg::*;

  rsi_state_e state_q, state_d;

  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] p_eff_w;
  logic [PERIOD_W-1:0] pm1_w;

  logic [PRICE_W-1:0]  prev_q;
  logic                seeded_q;
  logic                warmed_q;
  logic [PERIOD_W-1:0] wcnt_q;
  logic [PERIOD_W-1:0] wcnt_inc_w;
  logic                warm_done_w;
  logic                smooth_q;

  logic [PRICE_W-1:0]  gain_q, loss_q;
  logic [PRICE_W-1:0]  gain_w, loss_w;
  logic [AVG_W-1:0]    avg_g_q, avg_l_q;

  // Divider lanes: A serves gain and the ratio, B serves loss
  logic [DEN_W-1:0]    rem_a_q, rem_b_q, den_q;
  logic [AVG_W-1:0]    num_a_q, num_b_q;
  logic [STEP_W-1:0]   step_q;
  logic [DEN_W:0]      t_a_w, t_b_w, diff_a_w, diff_b_w;
  logic                ge_a_w, ge_b_w;
  logic [DEN_W-1:0]    rem_a_step_w, rem_b_step_w;

  logic [SMTH_W-1:0]   mul_g_w, mul_l_w, smth_g_w, smth_l_w;
  logic [PROD_W-1:0]   prod_w;

  logic                out_valid_q;
  logic [RSI_W-1:0]    rsi_q;

  logic                in_ready_w;
  logic                in_fire_w;
  logic                emit_fire_w;
  logic                out_pop_w;

  // Period clamp
  always_comb begin
    priority if (period_q < PERIOD_MIN) begin
      p_eff_w = PERIOD_MIN;
    end else if (period_q > PERIOD_MAX) begin
      p_eff_w = PERIOD_MAX;
    end else begin
      p_eff_w = period_q;
    end
  end
  assign pm1_w = p_eff_w - PERIOD_W'(1);

  // Change against previous close
  always_comb begin
    if (price_i.close_price >= prev_q) begin
      gain_w = price_i.close_price - prev_q;
      loss_w = '0;
    end else begin
      gain_w = '0;
      loss_w = prev_q - price_i.close_price;
    end
  end

  assign wcnt_inc_w  = wcnt_q + PERIOD_W'(1);
  assign warm_done_w = (wcnt_inc_w >= p_eff_w);

  // Smoothing numerators: (p-1)*avg + value<<FRAC
  assign mul_g_w  = SMTH_W'(avg_g_q) * SMTH_W'(pm1_w);
  assign mul_l_w  = SMTH_W'(avg_l_q) * SMTH_W'(pm1_w);
  assign smth_g_w = mul_g_w + SMTH_W'({gain_q, {FRAC_W{1'b0}}});
  assign smth_l_w = mul_l_w + SMTH_W'({loss_q, {FRAC_W{1'b0}}});

  // Ratio numerator: avg_gain * 10000
  assign prod_w = PROD_W'(avg_g_q) * PROD_W'(RSI_FULL);

  // One restoring-division step per lane
  assign t_a_w    = {rem_a_q, num_a_q[AVG_W-1]};
  assign t_b_w    = {rem_b_q, num_b_q[AVG_W-1]};
  assign diff_a_w = t_a_w - {1'b0, den_q};
  assign diff_b_w = t_b_w - {1'b0, den_q};
  assign ge_a_w   = (t_a_w >= {1'b0, den_q});
  assign ge_b_w   = (t_b_w >= {1'b0, den_q});
  assign rem_a_step_w = ge_a_w ? diff_a_w[DEN_W-1:0] : t_a_w[DEN_W-1:0];
  assign rem_b_step_w = ge_b_w ? diff_b_w[DEN_W-1:0] : t_b_w[DEN_W-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_w && seeded_q && (warmed_q || warm_done_w)) begin
          state_d = ST_PLOAD;
        end
      end
      ST_PLOAD:  state_d = ST_PDIV;
      ST_PDIV: begin
        if (step_q == STEP_W'(1)) begin
          state_d = ST_PSTORE;
        end
      end
      ST_PSTORE: state_d = smooth_q ? ST_RLOAD : ST_IDLE;
      ST_RLOAD:  state_d = ST_RDIV;
      ST_RDIV: begin
        if (step_q == STEP_W'(1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || rsi_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready_w  = (state_q == ST_IDLE);
    emit_fire_w = (state_q == ST_EMIT) && (!out_valid_q || rsi_o.ready);
    out_pop_w   = out_valid_q && rsi_o.ready;
  end

  assign in_fire_w       = price_i.valid && in_ready_w;
  assign price_i.ready   = in_ready_w;
  assign rsi_o.valid     = out_valid_q;
  assign rsi_o.rsi_value = rsi_q;

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      period_q    <= PERIOD_RST;
      prev_q      <= '0;
      seeded_q    <= 1'b0;
      warmed_q    <= 1'b0;
      wcnt_q      <= '0;
      avg_g_q     <= '0;
      avg_l_q     <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        period_q <= cfg_wdata_i;
      end

      // Accept: seed or accumulate warm-up sums
      if (in_fire_w) begin
        prev_q   <= price_i.close_price;
        seeded_q <= 1'b1;
        if (seeded_q && !warmed_q) begin
          avg_g_q <= avg_g_q + AVG_W'(gain_w);
          avg_l_q <= avg_l_q + AVG_W'(loss_w);
          wcnt_q  <= wcnt_inc_w;
        end
      end

      // Divider step count
      if (state_q == ST_PLOAD) begin
        step_q <= STEP_W'(AVG_W);
      end else if (state_q == ST_RLOAD) begin
        step_q <= STEP_W'(SCALE_W);
      end else if ((state_q == ST_PDIV) || (state_q == ST_RDIV)) begin
        step_q <= step_q - STEP_W'(1);
      end

      // New averages from the divider
      if (state_q == ST_PSTORE) begin
        avg_g_q <= num_a_q;
        avg_l_q <= num_b_q;
        if (!smooth_q) begin
          warmed_q <= 1'b1;
        end
      end

      // Output register
      if (emit_fire_w) begin
        out_valid_q <= 1'b1;
      end else if (out_pop_w) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    if (in_fire_w) begin
      gain_q   <= gain_w;
      loss_q   <= loss_w;
      smooth_q <= warmed_q;
    end

    unique case (state_q)
      ST_PLOAD: begin
        den_q <= DEN_W'(p_eff_w);
        if (smooth_q) begin
          rem_a_q <= DEN_W'(smth_g_w[SMTH_W-1:AVG_W]);
          num_a_q <= smth_g_w[AVG_W-1:0];
          rem_b_q <= DEN_W'(smth_l_w[SMTH_W-1:AVG_W]);
          num_b_q <= smth_l_w[AVG_W-1:0];
        end else begin
          rem_a_q <= '0;
          num_a_q <= {avg_g_q[SUM_W-1:0], {FRAC_W{1'b0}}};
          rem_b_q <= '0;
          num_b_q <= {avg_l_q[SUM_W-1:0], {FRAC_W{1'b0}}};
        end
      end
      ST_RLOAD: begin
        den_q   <= DEN_W'(avg_g_q) + DEN_W'(avg_l_q);
        rem_a_q <= DEN_W'(prod_w[PROD_W-1:SCALE_W]);
        num_a_q <= {prod_w[SCALE_W-1:0], {(AVG_W-SCALE_W){1'b0}}};
      end
      ST_PDIV, ST_RDIV: begin
        rem_a_q <= rem_a_step_w;
        num_a_q <= {num_a_q[AVG_W-2:0], ge_a_w};
        rem_b_q <= rem_b_step_w;
        num_b_q <= {num_b_q[AVG_W-2:0], ge_b_w};
      end
      default: begin
      end
    endcase

    // Both averages zero reads as an even market
    if (emit_fire_w) begin
      rsi_q <= (den_q == '0) ? RSI_EVEN : num_a_q[RSI_W-1:0];
    end
  end

endmodule
